>>> src/spq_pkg.sv
// Shared types, codes and sizes for the sorted priority queue.
`default_nettype none

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_UNUSED = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  // What the result register loads on a transaction.
  typedef enum logic [1:0] {
    RSP_NONE,
    RSP_HEAD,
    RSP_EMPTY,
    RSP_FULL
  } rsp_e;

  typedef struct packed {
    logic insert;
    logic remove;
    logic capture;
    rsp_e rsp;
  } spq_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } spq_stat_t;

endpackage : spq_pkg

`default_nettype wire

>>> src/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: controller plus cell-chain datapath.
//
//  channel   dir  tdata                                        tuser
//  s_axis    in   [31:0] item_value, [63:32] item_priority     [1:0] req_type
//  m_axis    out  [31:0] head_value, [63:32] head_priority,    [1:0] status
//                 [64] now_empty, [71:65] zero
//
// Each transaction updates the queue at the accepting edge, and the result
// shows from the next cycle. The input side waits until the
// result register has been taken, so a stalled output stalls the input.
// Reset empties the queue at once; entry contents are not cleared.
`default_nettype none

module sorted_priority_queue_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,  // item_value, item_priority
  input  wire logic [1:0]  s_axis_tuser_i,  // req_type
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [71:0]      m_axis_tdata_o,  // head_value, head_priority, now_empty
  output logic [1:0]       m_axis_tuser_o   // status
);
  import spq_pkg::*;

  spq_cmd_t          cmd;
  spq_stat_t         stat;
  logic [DATA_W-1:0] head_value, head_priority;
  logic [1:0]        status;
  logic              now_empty;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .req_type_i  (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  spq_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .item_value_i    (s_axis_tdata_i[31:0]),
    .item_priority_i (s_axis_tdata_i[63:32]),
    .stat_o          (stat),
    .head_value_o    (head_value),
    .head_priority_o (head_priority),
    .status_o        (status),
    .now_empty_o     (now_empty)
  );

  assign m_axis_tdata_o = {7'b0, now_empty, head_priority, head_value};
  assign m_axis_tuser_o = status;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input accepted while a result is pending");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.full |-> !stat.empty)
    else $error("queue reports full and empty together");

  a_remove_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == REQ_REMOVE) && !stat.empty)
      |=> (m_axis_tuser_o == ST_OK))
    else $error("remove from a nonempty queue did not report ok");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == ST_EMPTY)) |-> m_axis_tdata_o[64])
    else $error("empty status without now_empty");

endmodule : sorted_priority_queue_core

`default_nettype wire

>>> src/spq_ctrl.sv
// Controller: handshakes and per-transaction commands for the queue datapath.
`default_nettype none

module spq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        req_type_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire spq_pkg::spq_stat_t stat_i,
  output spq_pkg::spq_cmd_t      cmd_o
);
  import spq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = '{insert: 1'b0, remove: 1'b0, capture: accept, rsp: RSP_NONE};
    unique case (req_e'(req_type_i)) inside
      REQ_INSERT: begin
        if (stat_i.full) begin
          cmd_o.rsp = RSP_FULL;
        end else begin
          cmd_o.insert = accept;
        end
      end
      REQ_REMOVE, REQ_PEEK: begin
        if (stat_i.empty) begin
          cmd_o.rsp = RSP_EMPTY;
        end else begin
          cmd_o.rsp    = RSP_HEAD;
          cmd_o.remove = accept && (req_e'(req_type_i) == REQ_REMOVE);
        end
      end
      default: cmd_o.rsp = RSP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q     <= S_RESP;
            out_valid_q <= 1'b1;
          end
        end
        S_RESP: begin
          if (out_ready_i) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule : spq_ctrl

`default_nettype wire

>>> src/spq_datapath.sv
// Datapath: chain of compare-and-shift cells, entry count and result register.
`default_nettype none

module spq_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire spq_pkg::spq_cmd_t          cmd_i,
  input  wire logic [spq_pkg::DATA_W-1:0] item_value_i,
  input  wire logic [spq_pkg::DATA_W-1:0] item_priority_i,
  output spq_pkg::spq_stat_t              stat_o,
  output logic [spq_pkg::DATA_W-1:0]      head_value_o,
  output logic [spq_pkg::DATA_W-1:0]      head_priority_o,
  output logic [1:0]                      status_o,
  output logic                            now_empty_o
);
  import spq_pkg::*;

  logic [DATA_W-1:0] vals_q [CAPACITY];
  logic [DATA_W-1:0] pris_q [CAPACITY];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CAPACITY-1:0] stay;

  logic [DATA_W-1:0] res_val_q, res_pri_q;
  logic [1:0]        res_st_q;
  logic              res_empty_q;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CNT_W'(CAPACITY));

  // A cell keeps its entry when it lies ahead of the new one; the head wins ties.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        stay[i] = (CNT_W'(i) < count_q) &&
                  ($signed(pris_q[i]) >= $signed(item_priority_i));
      end else begin
        stay[i] = (CNT_W'(i) < count_q) &&
                  ($signed(pris_q[i]) > $signed(item_priority_i));
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (cmd_i.insert && !stay[g]) begin
        if (g == 0) begin
          vals_q[g] <= item_value_i;
          pris_q[g] <= item_priority_i;
        end else if (stay[(g > 0) ? g - 1 : 0]) begin
          vals_q[g] <= item_value_i;
          pris_q[g] <= item_priority_i;
        end else begin
          vals_q[g] <= vals_q[(g > 0) ? g - 1 : 0];
          pris_q[g] <= pris_q[(g > 0) ? g - 1 : 0];
        end
      end else if (cmd_i.remove && (g < CAPACITY - 1)) begin
        vals_q[g] <= vals_q[(g < CAPACITY - 1) ? g + 1 : g];
        pris_q[g] <= pris_q[(g < CAPACITY - 1) ? g + 1 : g];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.remove) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_empty_q <= (count_d == '0);
      case (cmd_i.rsp)
        RSP_HEAD: begin
          res_val_q <= vals_q[0];
          res_pri_q <= pris_q[0];
          res_st_q  <= ST_OK;
        end
        RSP_EMPTY: begin
          res_val_q <= EMPTY_VALUE;
          res_pri_q <= '0;
          res_st_q  <= ST_EMPTY;
        end
        RSP_FULL: begin
          res_val_q <= '0;
          res_pri_q <= '0;
          res_st_q  <= ST_FULL;
        end
        default: begin
          res_val_q <= '0;
          res_pri_q <= '0;
          res_st_q  <= ST_OK;
        end
      endcase
    end
  end

  assign head_value_o    = res_val_q;
  assign head_priority_o = res_pri_q;
  assign status_o        = res_st_q;
  assign now_empty_o     = res_empty_q;

endmodule : spq_datapath

`default_nettype wire

>>> tb/sorted_priority_queue_core_tb.sv
// Self-checking testbench for the sorted priority queue core: directed table plus random traffic.
`default_nettype none

module sorted_priority_queue_core_tb;
  import spq_pkg::*;

  localparam int N_RANDOM    = 725;
  localparam int CALM_ITEMS  = 100;
  localparam int PAUSE_AT    = 350;
  localparam int MODE_SPAN   = 32;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 8;

  typedef struct {
    req_e               req;
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } request_t;

  typedef struct {
    logic signed [31:0] value;
    logic signed [31:0] prio;
    status_e            status;
    logic               now_empty;
  } result_t;

  typedef struct {
    request_t rq;
    int       reps;
    bit       typed;
    result_t  res;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [63:0] s_data  = '0;
  logic [1:0]  s_user  = '0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [71:0] m_data;
  logic [1:0]  m_user;

  sorted_priority_queue_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  // Shadow copy of the queue contents, head in slot 0.
  logic signed [31:0] pq_value [CAPACITY];
  logic signed [31:0] pq_prio  [CAPACITY];
  int                 pq_count = 0;

  result_t   expected_q [$];
  stim_row_t stim_table [$];

  int errors      = 0;
  int idle_cycles = 0;
  bit calm        = 1'b0;
  int n_insert = 0, n_remove = 0, n_peek = 0, n_unused = 0;
  int n_full = 0, n_empty_read = 0, peak_depth = 0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Apply one request to the shadow queue and return the result it produces.
  function automatic result_t serve_request(request_t rq);
    result_t r;
    int      pos;
    r.value  = '0;
    r.prio   = '0;
    r.status = ST_OK;
    case (rq.req) inside
      REQ_INSERT: begin
        if (pq_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // Strictly higher priority takes the head; otherwise skip past the head
          // and every entry with strictly higher priority.
          if (pq_count == 0 || rq.prio > pq_prio[0]) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < pq_count && pq_prio[pos] > rq.prio) pos++;
          end
          for (int k = pq_count; k > pos; k--) begin
            pq_value[k] = pq_value[k-1];
            pq_prio[k]  = pq_prio[k-1];
          end
          pq_value[pos] = rq.value;
          pq_prio[pos]  = rq.prio;
          pq_count++;
        end
      end
      REQ_REMOVE, REQ_PEEK: begin
        if (pq_count == 0) begin
          r.value  = EMPTY_VALUE;
          r.status = ST_EMPTY;
        end else begin
          r.value = pq_value[0];
          r.prio  = pq_prio[0];
          if (rq.req == REQ_REMOVE) begin
            for (int k = 1; k < pq_count; k++) begin
              pq_value[k-1] = pq_value[k];
              pq_prio[k-1]  = pq_prio[k];
            end
            pq_count--;
          end
        end
      end
      default: ;
    endcase
    r.now_empty = (pq_count == 0);
    return r;
  endfunction

  function automatic void add_row(req_e req, logic [31:0] v, logic [31:0] p, int reps,
                                  bit typed, logic [31:0] ev, logic [31:0] ep,
                                  status_e st, logic ne);
    stim_row_t row;
    row.rq.req        = req;
    row.rq.value      = v;
    row.rq.prio       = p;
    row.reps          = reps;
    row.typed         = typed;
    row.res.value     = ev;
    row.res.prio      = ep;
    row.res.status    = st;
    row.res.now_empty = ne;
    stim_table.push_back(row);
  endfunction

  function automatic logic signed [31:0] random_prio();
    case ($urandom_range(0, 9)) inside
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      [2:4]:   return int'($urandom_range(0, 6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  // Mode 0 leans toward filling, mode 1 toward draining, mode 2 is mixed.
  function automatic request_t random_request(int mode);
    request_t rq;
    int       pick;
    int       ins_lim;
    int       rem_lim;
    pick     = $urandom_range(0, 99);
    rq.value = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 15)) : $urandom;
    rq.prio  = random_prio();
    ins_lim  = (mode == 0) ? 70 : (mode == 1) ? 30 : 50;
    rem_lim  = (mode == 0) ? 88 : 80;
    if (pick < 4)            rq.req = REQ_UNUSED;
    else if (pick < ins_lim) rq.req = REQ_INSERT;
    else if (pick < rem_lim) rq.req = REQ_REMOVE;
    else                     rq.req = REQ_PEEK;
    return rq;
  endfunction

  task automatic send_request(request_t rq, bit typed, result_t typed_res);
    result_t r;
    s_valid <= 1'b1;
    s_data  <= {rq.prio, rq.value};
    s_user  <= rq.req;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    r = serve_request(rq);
    if (typed) expected_q.push_back(typed_res);
    else       expected_q.push_back(r);
    case (rq.req)
      REQ_INSERT: n_insert++;
      REQ_REMOVE: n_remove++;
      REQ_PEEK:   n_peek++;
      default:    n_unused++;
    endcase
    if (r.status == ST_FULL)  n_full++;
    if (r.status == ST_EMPTY) n_empty_read++;
    if (pq_count > peak_depth) peak_depth = pq_count;
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    request_t rq;
    result_t  none;
    int       mode;
    none = '{value: '0, prio: '0, status: ST_OK, now_empty: 1'b0};
    mode = 0;

    // Empty-queue reads and the unused code right after reset, then inserts at the extreme priorities.
    add_row(REQ_REMOVE, 32'h0, 32'h0, 1, 1, 32'hFFFF_FFFF, 32'h0, ST_EMPTY, 1'b1);
    add_row(REQ_PEEK,   32'h0, 32'h0, 1, 1, 32'hFFFF_FFFF, 32'h0, ST_EMPTY, 1'b1);
    add_row(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 32'h0, 32'h0, ST_OK, 1'b1);
    add_row(REQ_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1, 32'h0, 32'h0, ST_OK, 1'b0);
    add_row(REQ_PEEK,   32'h0, 32'h0, 1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, ST_OK, 1'b0);
    add_row(REQ_INSERT, 32'h8000_0000, 32'h8000_0000, 1, 1, 32'h0, 32'h0, ST_OK, 1'b0);
    // Tie with the head, tie at the tail, tie in the middle.
    add_row(REQ_INSERT, 32'h1, 32'h7FFF_FFFF, 1, 0, 32'h0, 32'h0, ST_OK, 1'b0);
    add_row(REQ_INSERT, 32'h2, 32'h8000_0000, 1, 0, 32'h0, 32'h0, ST_OK, 1'b0);
    add_row(REQ_INSERT, 32'h3, 32'h0, 1, 0, 32'h0, 32'h0, ST_OK, 1'b0);
    add_row(REQ_INSERT, 32'h4, 32'h0, 1, 0, 32'h0, 32'h0, ST_OK, 1'b0);
    add_row(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 32'h0, 32'h0, ST_OK, 1'b0);
    add_row(REQ_PEEK,   32'h0, 32'h0, 1, 0, 32'h0, 32'h0, ST_OK, 1'b0);
    // Fill to capacity, then overflow.
    add_row(REQ_INSERT, 32'd100, -32'sd5, 11, 0, 32'h0, 32'h0, ST_OK, 1'b0);
    add_row(REQ_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 1, 32'h0, 32'h0, ST_FULL, 1'b0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      for (int j = 0; j < stim_table[i].reps; j++) begin
        rq        = stim_table[i].rq;
        rq.value += j;
        rq.prio  += j % 4;
        send_request(rq, stim_table[i].typed, stim_table[i].res);
        sender_gap();
      end
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % MODE_SPAN == 0) mode = $urandom_range(0, 2);
      if (n == N_RANDOM - CALM_ITEMS) calm = 1'b1;
      if (n == PAUSE_AT && expected_q.size() != 0) begin
        // Hold off until the queue has answered everything in flight.
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk_i);
      end
      send_request(random_request(mode), 1'b0, none);
      sender_gap();
    end
    s_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d inserts (%0d dropped on a full queue), %0d removes, %0d peeks,",
             n_insert, n_full, n_remove, n_peek);
    $display("%0d unused codes, %0d reads hit an empty queue, peak occupancy %0d of %0d",
             n_unused, n_empty_read, peak_depth, CAPACITY);
    $display("%0d mismatches", errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : sink_pacing
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      m_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      if (!calm) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d (0x%08h), actual %0d (0x%08h)",
               $time, name, $signed(want), want, $signed(got), got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transaction, tdata 0x%018h tuser %0d",
                 $time, m_data, m_user);
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("head_value", want.value, m_data[31:0]);
        check_field("head_priority", want.prio, m_data[63:32]);
        check_field("status", 32'(want.status), 32'(m_user));
        check_field("now_empty", 32'(want.now_empty), 32'(m_data[64]));
      end
    end
  end

  // Abort if neither side moves a transaction for too long.
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
    else if (rst_ni) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule : sorted_priority_queue_core_tb

`default_nettype wire
